[design/tcrd_pkg.sv]
`default_nettype none

package tcrd_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = 6;
    localparam int CNT_W        = VTX_W + 1;
    localparam int ROW_W        = 2 * MAX_VERTICES;
    localparam int DEG_W        = 7;

    localparam logic [DEG_W-1:0] DEG_MAX = 7'd127;

    typedef logic [1:0] colour_t;

    localparam colour_t COL_NONE  = 2'd0;
    localparam colour_t COL_BLACK = 2'd1;
    localparam colour_t COL_RED   = 2'd2;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_ADD      = 2'd0;
    localparam opcode_t OP_CONTRACT = 2'd1;
    localparam opcode_t OP_QUERY    = 2'd2;

endpackage

`default_nettype wire

[design/tcrd_ram.sv]
`default_nettype none

module tcrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/trigraph_contraction_red_degree.sv]
`default_nettype none
// Contraction: one matrix row read and rewritten per cycle.
// Throughput: one item at a time; a new input is accepted only in the idle state,
// after the result of the previous one has been loaded into the output register.
// Reset: asynchronous, active low. After reset a clearing pass over all MAX_VERTICES rows
// zeroes the matrix and the red degrees; no input is accepted during it.

module trigraph_contraction_red_degree (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    // [5:0] first_vertex, [11:6] second_vertex, [12] edge_red, [15:13] zero
    input  wire logic [15:0] s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0] s_axis_tuser,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    // [5:0] max_red_degree, [6] edge_found, [7] zero
    output logic      [7:0] m_axis_tdata
);

    import tcrd_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_WU,
        S_ADD_WV,
        S_QRY,
        S_CON,
        S_CON_FU,
        S_CON_FV,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [VTX_W-1:0] u_reg, u_next;
    logic [VTX_W-1:0] v_reg, v_next;
    logic             red_reg, red_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic             p_valid_reg, p_valid_next;
    logic [VTX_W-1:0] p_w_reg, p_w_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ROW_W-1:0] row_u_reg, row_u_next;
    logic             add_ok_reg, add_ok_next;
    logic             found_reg, found_next;
    logic [DEG_W-1:0] peak_reg, peak_next;
    logic             out_valid_reg, out_valid_next;
    logic [VTX_W-1:0] out_max_reg, out_max_next;
    logic             out_found_reg, out_found_next;

    logic             adj_we;
    logic [VTX_W-1:0] adj_waddr;
    logic [ROW_W-1:0] adj_wdata;
    logic [VTX_W-1:0] adj_raddr;
    logic [ROW_W-1:0] adj_rdata;
    logic             deg_we;
    logic [VTX_W-1:0] deg_waddr;
    logic [DEG_W-1:0] deg_wdata;
    logic [VTX_W-1:0] deg_raddr;
    logic [DEG_W-1:0] deg_rdata;

    logic [VTX_W-1:0] in_first;
    logic [VTX_W-1:0] in_second;
    logic             in_red;
    opcode_t          in_op;
    logic             in_valid_item;
    colour_t          colour;
    colour_t          col_a;
    colour_t          col_b;
    colour_t          merged;
    logic [ROW_W-1:0] row_mod;
    logic [DEG_W-1:0] deg_inc;
    logic [DEG_W-1:0] count_sat;

    assign in_first  = s_axis_tdata[5:0];
    assign in_second = s_axis_tdata[11:6];
    assign in_red    = s_axis_tdata[12];
    assign in_op     = s_axis_tuser;

    assign in_valid_item = (int'(in_first) < MAX_VERTICES) && (int'(in_second) < MAX_VERTICES)
                           && (in_first != in_second);

    assign colour = red_reg ? COL_RED : COL_BLACK;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_found_reg, out_max_reg};

    tcrd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    tcrd_ram #(
        .WIDTH (DEG_W),
        .DEPTH (MAX_VERTICES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        red_next       = red_reg;
        w_next         = w_reg;
        p_valid_next   = p_valid_reg;
        p_w_next       = p_w_reg;
        count_next     = count_reg;
        row_u_next     = row_u_reg;
        add_ok_next    = add_ok_reg;
        found_next     = found_reg;
        peak_next      = peak_reg;
        out_valid_next = out_valid_reg;
        out_max_next   = out_max_reg;
        out_found_next = out_found_reg;

        adj_we    = 1'b0;
        adj_waddr = u_reg;
        adj_wdata = '0;
        adj_raddr = u_reg;
        deg_we    = 1'b0;
        deg_waddr = u_reg;
        deg_wdata = '0;
        deg_raddr = w_reg[VTX_W-1:0];

        row_mod = adj_rdata;
        col_a   = adj_rdata[2*u_reg +: 2];
        col_b   = adj_rdata[2*v_reg +: 2];
        merged  = COL_NONE;
        deg_inc = (deg_rdata < DEG_MAX) ? deg_rdata + 7'd1 : deg_rdata;
        count_sat = (count_reg > CNT_W'(DEG_MAX)) ? DEG_MAX : DEG_W'(count_reg);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                adj_we    = 1'b1;
                adj_waddr = w_reg[VTX_W-1:0];
                deg_we    = 1'b1;
                deg_waddr = w_reg[VTX_W-1:0];
                if (int'(w_reg) == MAX_VERTICES - 1)
                begin
                    w_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next = w_reg + CNT_W'(1);
                end
            end

            S_IDLE:
            begin
                adj_raddr = in_first;
                if (s_axis_tvalid)
                begin
                    u_next       = in_first;
                    v_next       = in_second;
                    red_next     = in_red;
                    found_next   = 1'b0;
                    w_next       = '0;
                    p_valid_next = 1'b0;
                    count_next   = '0;
                    row_u_next   = '0;
                    if (!in_valid_item)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        unique case (in_op)
                            OP_ADD:      state_next = S_ADD_WU;
                            OP_CONTRACT: state_next = S_CON;
                            OP_QUERY:    state_next = S_QRY;
                            default:     state_next = S_RESP;
                        endcase
                    end
                end
            end

            S_ADD_WU:
            begin
                // Row u is checked alone; the matrix is kept symmetric.
                add_ok_next = (col_b == COL_NONE);
                row_mod[2*v_reg +: 2] = colour;
                adj_we     = (col_b == COL_NONE);
                adj_waddr  = u_reg;
                adj_wdata  = row_mod;
                adj_raddr  = v_reg;
                state_next = S_ADD_WV;
            end

            S_ADD_WV:
            begin
                row_mod[2*u_reg +: 2] = colour;
                adj_we     = add_ok_reg;
                adj_waddr  = v_reg;
                adj_wdata  = row_mod;
                state_next = S_RESP;
            end

            S_QRY:
            begin
                found_next = (col_b == colour);
                state_next = S_RESP;
            end

            S_CON:
            begin
                adj_raddr = w_reg[VTX_W-1:0];
                if (!w_reg[VTX_W])
                begin
                    p_valid_next = 1'b1;
                    p_w_next     = w_reg[VTX_W-1:0];
                    w_next       = w_reg + CNT_W'(1);
                end
                else
                begin
                    p_valid_next = 1'b0;
                    state_next   = S_CON_FU;
                end

                // Row w arrives in the cycle after its read; merge its u and v entries.
                if (p_valid_reg && (p_w_reg != u_reg) && (p_w_reg != v_reg))
                begin
                    deg_wdata = deg_rdata;
                    if (col_a != COL_NONE && col_b == COL_NONE)
                    begin
                        merged = COL_RED;
                        if (col_a != COL_RED)
                        begin
                            deg_wdata = deg_inc;
                        end
                    end
                    else if (col_b != COL_NONE && col_a == COL_NONE)
                    begin
                        merged = COL_RED;
                        if (col_b != COL_RED)
                        begin
                            deg_wdata = deg_inc;
                        end
                    end
                    else if (col_a != COL_NONE && col_b != COL_NONE)
                    begin
                        merged = (col_a == COL_RED || col_b == COL_RED) ? COL_RED : COL_BLACK;
                        if (col_a == COL_RED && col_b == COL_RED && deg_rdata != '0)
                        begin
                            deg_wdata = deg_rdata - 7'd1;
                        end
                    end

                    if (deg_wdata > peak_reg)
                    begin
                        peak_next = deg_wdata;
                    end

                    row_mod[2*u_reg +: 2] = merged;
                    row_mod[2*v_reg +: 2] = COL_NONE;
                    adj_we    = 1'b1;
                    adj_waddr = p_w_reg;
                    adj_wdata = row_mod;
                    deg_we    = 1'b1;
                    deg_waddr = p_w_reg;

                    row_u_next[2*p_w_reg +: 2] = merged;
                    if (merged == COL_RED)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end

            S_CON_FU:
            begin
                adj_we    = 1'b1;
                adj_waddr = u_reg;
                adj_wdata = row_u_reg;
                deg_we    = 1'b1;
                deg_waddr = u_reg;
                deg_wdata = count_sat;
                if (count_sat > peak_reg)
                begin
                    peak_next = count_sat;
                end
                state_next = S_CON_FV;
            end

            S_CON_FV:
            begin
                adj_we     = 1'b1;
                adj_waddr  = v_reg;
                deg_we     = 1'b1;
                deg_waddr  = v_reg;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_max_next   = peak_reg[VTX_W-1:0];
                    out_found_next = found_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            u_reg         <= '0;
            v_reg         <= '0;
            red_reg       <= 1'b0;
            w_reg         <= '0;
            p_valid_reg   <= 1'b0;
            p_w_reg       <= '0;
            count_reg     <= '0;
            row_u_reg     <= '0;
            add_ok_reg    <= 1'b0;
            found_reg     <= 1'b0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_max_reg   <= '0;
            out_found_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            red_reg       <= red_next;
            w_reg         <= w_next;
            p_valid_reg   <= p_valid_next;
            p_w_reg       <= p_w_next;
            count_reg     <= count_next;
            row_u_reg     <= row_u_next;
            add_ok_reg    <= add_ok_next;
            found_reg     <= found_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
            out_max_reg   <= out_max_next;
            out_found_reg <= out_found_next;
        end
    end

endmodule

`default_nettype wire
